// ----- sv/swsp_pkg.sv -----
// ----------------------------------------------------------------------------
// swsp_pkg
// Types and character constants shared by the shell word splitter modules.
// ----------------------------------------------------------------------------
package swsp_pkg;

  // Parse modes, one-hot
  typedef enum logic [4:0] {
    M_NORMAL = 5'b00001,
    M_BSL    = 5'b00010,
    M_SQ     = 5'b00100,
    M_DQ     = 5'b01000,
    M_DQ_BSL = 5'b10000
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    K_BYTE  = 2'd0,
    K_END   = 2'd1,
    K_DONE  = 2'd2,
    K_ERROR = 2'd3
  } kind_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChBsl   = 8'h5C;

  // One result entry
  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_v;
    logic       last;
  } res_t;

  // Decoder outcome for one input byte
  typedef struct packed {
    mode_e      mode_nxt;
    logic       open_nxt;
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_t;

endpackage

// ----- sv/swsp_decode.sv -----
// ----------------------------------------------------------------------------
// swsp_decode
// Mode machine step: next mode, word state and up to two results per byte.
// ----------------------------------------------------------------------------
module swsp_decode (
  input  swsp_pkg::mode_e mode_i,
  input  logic            word_open_i,
  input  logic [7:0]      ch_i,
  output swsp_pkg::dec_t  dec_o
);
  import swsp_pkg::*;

  res_t       r0, r1;
  mode_e      mode_nxt;
  logic       open_nxt;
  logic [1:0] num;

  always_comb begin
    mode_nxt = mode_i;
    open_nxt = word_open_i;
    num      = 2'd0;
    r0       = '{kind: K_BYTE, char_v: 8'h00, last: 1'b0};
    r1       = '{kind: K_BYTE, char_v: 8'h00, last: 1'b0};
    case (mode_i)
      M_BSL: begin
        mode_nxt = M_NORMAL;
        if (ch_i == ChNul) begin
          open_nxt  = 1'b0;
          r0.kind   = K_ERROR;
          num       = 2'd1;
        end else if (ch_i != ChNl) begin
          open_nxt  = 1'b1;
          r0.char_v = ch_i;
          num       = 2'd1;
        end
      end
      M_SQ: begin
        if (ch_i == ChNul) begin
          mode_nxt = M_NORMAL;
          open_nxt = 1'b0;
          r0.kind  = K_ERROR;
          num      = 2'd1;
        end else if (ch_i == ChSq) begin
          // closing quote; empty word if nothing collected
          mode_nxt = M_NORMAL;
          if (!word_open_i) begin
            r0.kind = K_END;
            num     = 2'd1;
          end
        end else begin
          open_nxt  = 1'b1;
          r0.char_v = ch_i;
          num       = 2'd1;
        end
      end
      M_DQ: begin
        if (ch_i == ChNul) begin
          mode_nxt = M_NORMAL;
          open_nxt = 1'b0;
          r0.kind  = K_ERROR;
          num      = 2'd1;
        end else if (ch_i == ChDq) begin
          mode_nxt = M_NORMAL;
          if (!word_open_i) begin
            r0.kind = K_END;
            num     = 2'd1;
          end
        end else if (ch_i == ChBsl) begin
          mode_nxt = M_DQ_BSL;
        end else begin
          open_nxt  = 1'b1;
          r0.char_v = ch_i;
          num       = 2'd1;
        end
      end
      M_DQ_BSL: begin
        if (ch_i == ChNul) begin
          mode_nxt = M_NORMAL;
          open_nxt = 1'b0;
          r0.kind  = K_ERROR;
          num      = 2'd1;
        end else begin
          mode_nxt = M_DQ;
          if (ch_i == ChDq || ch_i == ChBsl) begin
            open_nxt  = 1'b1;
            r0.char_v = ch_i;
            num       = 2'd1;
          end else if (ch_i != ChNl) begin
            // backslash kept ahead of the byte
            open_nxt  = 1'b1;
            r0.char_v = ChBsl;
            r1.char_v = ch_i;
            num       = 2'd2;
          end
        end
      end
      default: begin
        mode_nxt = M_NORMAL;
        if (ch_i == ChNul) begin
          open_nxt = 1'b0;
          if (word_open_i) begin
            r0.kind = K_END;
            r1.kind = K_DONE;
            num     = 2'd2;
          end else begin
            r0.kind = K_DONE;
            num     = 2'd1;
          end
        end else if (ch_i == ChBsl) begin
          mode_nxt = M_BSL;
        end else if (ch_i == ChDq) begin
          mode_nxt = M_DQ;
        end else if (ch_i == ChSq) begin
          mode_nxt = M_SQ;
        end else if (ch_i == ChSpace || ch_i == ChTab) begin
          if (word_open_i) begin
            open_nxt = 1'b0;
            r0.kind  = K_END;
            num      = 2'd1;
          end
        end else begin
          open_nxt  = 1'b1;
          r0.char_v = ch_i;
          num       = 2'd1;
        end
      end
    endcase
    // last flag on the final result of this byte
    r0.last = (num == 2'd1);
    r1.last = (num == 2'd2);
  end

  assign dec_o = '{mode_nxt: mode_nxt, open_nxt: open_nxt, num: num, r0: r0, r1: r1};

endmodule

// ----- sv/swsp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// swsp_out_fifo
// Result queue: takes up to two entries per cycle, hands out one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module swsp_out_fifo #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_num_i,
  input  swsp_pkg::res_t  push0_i,
  input  swsp_pkg::res_t  push1_i,
  output logic            room2_o,
  output logic            valid_o,
  input  logic            ready_i,
  output swsp_pkg::res_t  head_o
);
  import swsp_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_idx1;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room2_o = (cnt_q <= CntW'(FifoDepth - 2));
  assign wr_idx1 = ptr_inc(wr_ptr_q);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    case (push_num_i)
      2'd1:    wr_ptr_d = wr_idx1;
      2'd2:    wr_ptr_d = ptr_inc(wr_idx1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_num_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_idx1] <= push1_i;
    end
  end

endmodule

// ----- sv/shell_word_splitter_core.sv -----
// ----------------------------------------------------------------------------
// shell_word_splitter_core
// Splits a NUL-terminated byte string into shell words, one byte per cycle while in_ready_o is high.
// ----------------------------------------------------------------------------
// Input channel: one string byte per request (ch_i), in_valid_i/in_ready_o.
//   A zero byte ends the string; the parser then returns to its reset state.
// Output channel: one result per request, out_valid_o/out_ready_i, with
//   out_kind_o (word byte, word end, done, syntax error), out_char_o and
//   last_o marking the final result produced by one input byte.
// Results pass through the registered result queue and come out in order.
// Throughput: one byte per cycle while in_ready_o is high. A byte gives zero,
//   one or two results; the output drains one result per cycle while out_ready_i
//   is high, so two-result bytes (kept backslash in double quotes, word end before done) leave one waiting.
// in_ready_o is high while the result queue has two free entries, so it
//   does not depend on out_ready_i in the same cycle.
// Receiver stall: results wait in the queue (FifoDepth entries); input is
//   held off once fewer than two entries are free.
// Reset: mode returns to unquoted, no word open, queue empty.
// On a syntax error the receiver should discard the words of that string.
// ----------------------------------------------------------------------------
module shell_word_splitter_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_char_o,
  output logic       last_o
);
  import swsp_pkg::*;

  mode_e      mode_q, mode_d;
  logic       open_q, open_d;
  dec_t       dec;
  logic       accept;
  logic [1:0] push_num;
  res_t       head;

  swsp_decode u_decode (
    .mode_i      (mode_q),
    .word_open_i (open_q),
    .ch_i        (ch_i),
    .dec_o       (dec)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign push_num = accept ? dec.num : 2'd0;
  assign mode_d   = accept ? dec.mode_nxt : mode_q;
  assign open_d   = accept ? dec.open_nxt : open_q;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      open_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      open_q <= open_d;
    end
  end

  swsp_out_fifo #(
    .FifoDepth (FifoDepth)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push0_i    (dec.r0),
    .push1_i    (dec.r1),
    .room2_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .head_o     (head)
  );

  assign out_kind_o = head.kind;
  assign out_char_o = head.char_v;
  assign last_o     = head.last;

endmodule

// ----- sv/swsp_checker.sv -----
// ----------------------------------------------------------------------------
// swsp_checker
// Port-level checks for the shell word splitter, bound to the top level.
// ----------------------------------------------------------------------------
module swsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_char_o,
  input logic       last_o
);
  import swsp_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_kind_o) && $stable(out_char_o) && $stable(last_o))
    else $error("result payload changed while stalled");

  // only word bytes carry a character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != K_BYTE) |-> (out_char_o == 8'h00))
    else $error("non-byte result with nonzero char");

  // done and error always close the byte's results
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == K_DONE || out_kind_o == K_ERROR) |-> last_o)
    else $error("done or error without last");

endmodule

bind shell_word_splitter_core swsp_checker u_swsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_kind_o  (out_kind_o),
  .out_char_o  (out_char_o),
  .last_o      (last_o)
);

// ----- verif/word_split_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_split_checker
// Watches both request channels of the shell word splitter, works out the
// result stream that each accepted byte should cause and compares it, field
// by field and in order, with the results the block hands out.
// ----------------------------------------------------------------------------
module word_split_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned due_count_o
);
  import swsp_pkg::*;

  // Parser state as the block should hold it
  mode_e split_mode;
  logic  word_open;

  // Results of the byte being split, then the ordered list still owed
  res_t  step_res [2];
  int    step_n;
  res_t  results_due [$];
  res_t  want;

  // Append one result of the current byte; a word byte opens the word
  function void emit(kind_e k, logic [7:0] c);
    step_res[step_n] = '{kind: k, char_v: (k == K_BYTE) ? c : ChNul, last: 1'b0};
    if (k == K_BYTE) begin
      word_open = 1'b1;
    end
    step_n++;
  endfunction

  // Done or syntax error: back to the start of a new string
  function void end_string(kind_e k);
    split_mode = M_NORMAL;
    word_open  = 1'b0;
    emit(k, ChNul);
  endfunction

  // Closing quote; with nothing collected it stands for an empty word
  function void close_quote();
    split_mode = M_NORMAL;
    if (!word_open) begin
      emit(K_END, ChNul);
    end
  endfunction

  // Split one input byte and queue the results it causes
  task split_byte(input logic [7:0] c);
    step_n = 0;
    case (split_mode)
      M_BSL: begin
        if (c == ChNul) begin
          end_string(K_ERROR);
        end else begin
          split_mode = M_NORMAL;
          if (c != ChNl) begin
            emit(K_BYTE, c);
          end
        end
      end
      M_SQ: begin
        if (c == ChNul) begin
          end_string(K_ERROR);
        end else if (c == ChSq) begin
          close_quote();
        end else begin
          emit(K_BYTE, c);
        end
      end
      M_DQ: begin
        if (c == ChNul) begin
          end_string(K_ERROR);
        end else if (c == ChDq) begin
          close_quote();
        end else if (c == ChBsl) begin
          split_mode = M_DQ_BSL;
        end else begin
          emit(K_BYTE, c);
        end
      end
      M_DQ_BSL: begin
        if (c == ChNul) begin
          end_string(K_ERROR);
        end else begin
          split_mode = M_DQ;
          // only quote and backslash are escaped; newline is swallowed
          if (c == ChDq || c == ChBsl) begin
            emit(K_BYTE, c);
          end else if (c != ChNl) begin
            emit(K_BYTE, ChBsl);
            emit(K_BYTE, c);
          end
        end
      end
      default: begin
        split_mode = M_NORMAL;
        if (c == ChNul) begin
          if (word_open) begin
            emit(K_END, ChNul);
          end
          end_string(K_DONE);
        end else if (c == ChBsl) begin
          split_mode = M_BSL;
        end else if (c == ChDq) begin
          split_mode = M_DQ;
        end else if (c == ChSq) begin
          split_mode = M_SQ;
        end else if (c == ChSpace || c == ChTab) begin
          if (word_open) begin
            emit(K_END, ChNul);
            word_open = 1'b0;
          end
        end else begin
          emit(K_BYTE, c);
        end
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n - 1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      results_due.push_back(step_res[i]);
    end
  endtask

  // Predict on input requests, compare on output requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_mode   = M_NORMAL;
      word_open    = 1'b0;
      fail_count_o = 0;
      results_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        split_byte(ch_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result with nothing owed: kind %0d char 0x%02h last %0d",
                 out_kind_i, out_char_i, last_i);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          if (out_kind_i != want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind_i);
            fail_count_o++;
          end
          if (out_char_i != want.char_v) begin
            $error("out_char: expected 0x%02h, actual 0x%02h", want.char_v, out_char_i);
            fail_count_o++;
          end
          if (last_i != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            fail_count_o++;
          end
        end
      end
    end
    due_count_o = results_due.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the shell word splitter: a short hand-picked set
// of corner strings, then random strings built from plain, escaped and
// quoted words with some noise and cut-off strings, under changing
// backpressure on both sides. The checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench;
  import swsp_pkg::*;

  typedef enum int {
    TOK_PLAIN,
    TOK_ESCAPED,
    TOK_SINGLE,
    TOK_DOUBLE,
    TOK_EMPTY
  } token_e;

  localparam int unsigned RandomItems   = 1450;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 20;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  ch        = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_char;
  logic        res_last;
  int unsigned fail_count;
  int unsigned due_count;

  int unsigned in_idle_pct  = 13;
  int unsigned out_idle_pct = 77;
  int unsigned stall_cycles = 0;
  int unsigned random_sent  = 0;
  int unsigned phase        = 0;
  logic [7:0]  directed_bytes [$];
  logic [7:0]  string_bytes [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  shell_word_splitter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .ch_i        (ch),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_kind_o  (out_kind),
    .out_char_o  (out_char),
    .last_o      (res_last)
  );

  word_split_checker split_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .ch_i         (ch),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_kind_i   (out_kind),
    .out_char_i   (out_char),
    .last_i       (res_last),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= out_idle_pct);
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  // Any nonzero byte that neither quotes, escapes nor separates
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      c = rand_byte(1, 255);
    end while (c == ChSpace || c == ChTab || c == ChDq || c == ChSq || c == ChBsl);
    return c;
  endfunction

  // One request on the input side, with random gaps in front
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Hold the sender off until every owed result has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_count != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic push_separator();
    repeat ($urandom_range(2, 1)) begin
      string_bytes.push_back($urandom_range(1, 0) ? ChSpace : ChTab);
    end
  endtask

  // One word piece: plain, escaped, quoted or an empty quote pair
  task automatic add_token();
    token_e     tok;
    int unsigned n;
    logic [7:0] c;
    tok = token_e'($urandom_range(4, 0));
    n   = $urandom_range(4, 1);
    case (tok)
      TOK_PLAIN: begin
        repeat (n) string_bytes.push_back(word_char());
      end
      TOK_ESCAPED: begin
        string_bytes.push_back(ChBsl);
        string_bytes.push_back(($urandom_range(3, 0) == 0) ? ChNl : rand_byte(1, 255));
      end
      TOK_SINGLE: begin
        string_bytes.push_back(ChSq);
        repeat (n) begin
          do begin
            c = rand_byte(1, 255);
          end while (c == ChSq);
          string_bytes.push_back(c);
        end
        string_bytes.push_back(ChSq);
      end
      TOK_DOUBLE: begin
        string_bytes.push_back(ChDq);
        repeat (n) begin
          if ($urandom_range(3, 0) == 0) begin
            // escape: quote, backslash, newline or a kept backslash
            string_bytes.push_back(ChBsl);
            case ($urandom_range(3, 0))
              0:       string_bytes.push_back(ChDq);
              1:       string_bytes.push_back(ChBsl);
              2:       string_bytes.push_back(ChNl);
              default: string_bytes.push_back(rand_byte(1, 255));
            endcase
          end else begin
            do begin
              c = rand_byte(1, 255);
            end while (c == ChDq || c == ChBsl);
            string_bytes.push_back(c);
          end
        end
        string_bytes.push_back(ChDq);
      end
      default: begin
        c = $urandom_range(1, 0) ? ChSq : ChDq;
        string_bytes.push_back(c);
        string_bytes.push_back(c);
      end
    endcase
  endtask

  // Mostly well-formed strings; some raw noise and some cut short
  task automatic build_string();
    int unsigned cut;
    string_bytes.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(8, 1)) string_bytes.push_back(rand_byte(0, 255));
    end else begin
      if ($urandom_range(3, 0) == 0) begin
        push_separator();
      end
      repeat ($urandom_range(4, 1)) begin
        add_token();
        if ($urandom_range(4, 0) != 0) begin
          push_separator();
        end
      end
      if ($urandom_range(9, 0) == 0) begin
        cut = $urandom_range(string_bytes.size(), 1);
        repeat (cut) string_bytes.delete(string_bytes.size() - 1);
      end
      string_bytes.push_back(ChNul);
    end
  endtask

  // Stimulus and verdict
  initial begin
    directed_bytes = {
      // separator with no word, top byte, word end, low byte, end and done
      ChTab, 8'hFF, ChSpace, 8'h01, ChNul,
      // empty word, escaped newline, bare newline, backslash at end
      ChSq, ChSq, ChBsl, ChNl, ChNl, ChBsl, ChNul,
      // double-quote escapes, kept backslash, tab ends word, open quote at end
      ChDq, ChBsl, ChDq, ChBsl, ChBsl, ChBsl, 8'h71, ChBsl, ChNl, ChDq,
      ChTab, ChSq, ChNul,
      // backslash inside double quotes at end
      ChDq, ChBsl, ChNul
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_for_results();

    while (random_sent < RandomItems) begin
      if (phase == 0 && random_sent >= RandomItems / 3) begin
        wait_for_results();
        in_idle_pct  = 77;
        out_idle_pct = 13;
        phase        = 1;
      end else if (phase == 1 && random_sent >= 2 * RandomItems / 3) begin
        wait_for_results();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        phase        = 2;
      end else if ($urandom_range(29, 0) == 0) begin
        wait_for_results();
      end
      build_string();
      foreach (string_bytes[i]) send_byte(string_bytes[i]);
      random_sent += string_bytes.size();
    end

    wait_for_results();
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
